/* hw/rtl/tpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants for the tag presence tracker.
// ----------------------------------------------------------------------------
package tpt_pkg;

	localparam int OPCODE_W = 1;
	localparam int INDEX_W  = 5;
	localparam int TID_W    = 64;
	localparam int LEN_W    = 4;
	localparam int MISS_W   = 16;
	localparam int COUNT_W  = 6;
	localparam int REG_W    = 1;
	localparam int CFG_W    = 16;

	localparam logic [OPCODE_W-1:0] OP_READ = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b1;

	localparam logic [REG_W-1:0] REG_MAX_MISSES  = 1'b0;
	localparam logic [REG_W-1:0] REG_ENTRY_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [INDEX_W-1:0] entry;
		logic               present;
	} event_t;

endpackage

/* hw/rtl/tpt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_if
// Valid/ready channels: request beats, event beats, register writes.
// ----------------------------------------------------------------------------
interface tpt_req_if;
	logic                         valid;
	logic                         ready;
	logic [tpt_pkg::OPCODE_W-1:0] opcode;
	logic [tpt_pkg::INDEX_W-1:0]  entry_index;
	logic [tpt_pkg::TID_W-1:0]    tid_value;
	logic [tpt_pkg::LEN_W-1:0]    tid_length;

	modport source (output valid, opcode, entry_index, tid_value, tid_length, input ready);
	modport sink   (input valid, opcode, entry_index, tid_value, tid_length, output ready);
endinterface

interface tpt_evt_if;
	logic                        valid;
	logic                        ready;
	logic [tpt_pkg::INDEX_W-1:0] changed_entry;
	logic                        now_present;
	logic                        last_event;

	modport source (output valid, changed_entry, now_present, last_event, input ready);
	modport sink   (input valid, changed_entry, now_present, last_event, output ready);
endinterface

interface tpt_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [tpt_pkg::REG_W-1:0] index;
	logic [tpt_pkg::CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/tpt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tpt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hw/rtl/tag_presence_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_presence_tracker
// Tracks which loaded tag IDs are present and reports each presence change.
//
//   port  dir   beat
//   req   sink  table load or tag read
//   evt   src   one presence change, last_event on the final one of a read
//   cfg   sink  register write (max_misses, entry_count)
//
// A load writes both RAMs as it is accepted. A read runs the accept, one pass
// over the TID RAM to find the highest matching entry, one pass over the
// miss-counter RAM to update counters and flags, and a flush of the pending
// beat. req is ready only between reads. Reset clears presence and
// counter-valid flops at once; no clearing pass. A stalled evt holds the
// update pass once the output register and the one-deep pending beat are both
// full.
// ----------------------------------------------------------------------------
module tag_presence_tracker #(
	parameter int ENTRIES   = 32,
	parameter int TID_BYTES = 8
) (
	input  logic clk,
	input  logic arst_n,
	tpt_req_if.sink   req,
	tpt_evt_if.source evt,
	tpt_cfg_if.sink   cfg
);
	import tpt_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int TW = 8 * TID_BYTES;
	localparam logic [6:0] ENT7 = 7'(ENTRIES);
	localparam logic [LEN_W-1:0] TB_LEN = LEN_W'(TID_BYTES);

	state_t state_q, state_d;

	logic [MISS_W-1:0]  max_misses_q;
	logic [COUNT_W-1:0] entry_count_q;

	logic [CW-1:0]     rd_q;
	logic [CW-1:0]     used_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic [TW-1:0]     tid_q;
	logic [TW-1:0]     mask_q;
	logic [MISS_W-1:0] limit_q;
	logic              hit_vld_q;
	logic [IW-1:0]     hit_q;
	logic [ENTRIES-1:0] pres_q;
	logic [ENTRIES-1:0] cval_q;
	logic              pend_vld_q;
	event_t            pend_q;
	logic              out_vld_q;
	event_t            out_q;
	logic              out_last_q;

	logic              accept, load_acc, read_go, idx_ok;
	logic [IW-1:0]     load_addr;
	logic [6:0]        used_c;
	logic [LEN_W-1:0]  len_c;
	logic [TW-1:0]     mask_c;
	logic [TW-1:0]     tid_rd;
	logic [MISS_W-1:0] cnt_dout, cnt_rd, cnt_new;
	logic              more, issue, stall, step, match_hit;
	logic              is_hit, pres_old, ev_present, ev_absent, ev;
	logic              out_free, flush_go, out_from_step;
	logic              tid_re, cnt_we, cnt_re;
	logic [IW-1:0]     cnt_waddr;
	logic [MISS_W-1:0] cnt_wdata;

	// request decode
	always_comb begin
		accept    = req.valid && req.ready;
		idx_ok    = {2'b00, req.entry_index} < ENT7;
		load_addr = IW'(req.entry_index);
		load_acc  = accept && (req.opcode == OP_LOAD) && idx_ok;
		used_c    = ({1'b0, entry_count_q} > ENT7) ? ENT7 : {1'b0, entry_count_q};
		len_c     = (req.tid_length > TB_LEN) ? TB_LEN : req.tid_length;
		read_go   = accept && (req.opcode == OP_READ) && (req.tid_length != '0)
			&& (used_c != '0);
		for (int b = 0; b < TID_BYTES; b++) begin
			mask_c[b*8 +: 8] = {8{LEN_W'(b) < len_c}};
		end
	end

	// datapath for the two passes
	always_comb begin
		more      = rd_q < used_q;
		out_free  = !out_vld_q || evt.ready;
		match_hit = vld_s1 && (((tid_rd ^ tid_q) & mask_q) == '0);
		cnt_rd    = cval_q[idx_s1] ? cnt_dout : '0;
		is_hit    = hit_vld_q && (hit_q == idx_s1);
		if (is_hit) begin
			cnt_new = '0;
		end else if (cnt_rd < limit_q) begin
			cnt_new = cnt_rd + MISS_W'(1);
		end else begin
			cnt_new = cnt_rd;
		end
		pres_old   = pres_q[idx_s1];
		ev_present = is_hit && !pres_old;
		ev_absent  = !is_hit && pres_old && (cnt_new >= limit_q);
		ev         = ev_present || ev_absent;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (read_go) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				if (!more && !vld_s1) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!more && !vld_s1) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready     = 1'b0;
		stall         = 1'b0;
		step          = 1'b0;
		issue         = 1'b0;
		tid_re        = 1'b0;
		cnt_re        = 1'b0;
		flush_go      = 1'b0;
		out_from_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_MATCH: begin
				issue  = more;
				tid_re = more;
			end
			ST_UPDATE: begin
				stall         = vld_s1 && ev && pend_vld_q && !out_free;
				step          = vld_s1 && !stall;
				issue         = more && !stall;
				cnt_re        = issue;
				out_from_step = step && ev && pend_vld_q;
			end
			ST_FLUSH: begin
				flush_go = !pend_vld_q || out_free;
			end
			default: req.ready = 1'b0;
		endcase
		cnt_we    = load_acc || step;
		cnt_waddr = load_acc ? load_addr : idx_s1;
		cnt_wdata = load_acc ? '0 : cnt_new;
	end

	tpt_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_tid_ram (
		.clk   (clk),
		.we    (load_acc),
		.waddr (load_addr),
		.wdata (req.tid_value[TW-1:0]),
		.re    (tid_re),
		.raddr (rd_q[IW-1:0]),
		.rdata (tid_rd)
	);

	tpt_ram #(.WIDTH(MISS_W), .DEPTH(ENTRIES)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (rd_q[IW-1:0]),
		.rdata (cnt_dout)
	);

	assign cfg.ready         = 1'b1;
	assign evt.valid         = out_vld_q;
	assign evt.changed_entry = out_q.entry;
	assign evt.now_present   = out_q.present;
	assign evt.last_event    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			max_misses_q  <= MISS_W'(10);
			entry_count_q <= '0;
			rd_q          <= '0;
			used_q        <= '0;
			vld_s1        <= 1'b0;
			hit_vld_q     <= 1'b0;
			pres_q        <= '0;
			cval_q        <= '0;
			pend_vld_q    <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_MAX_MISSES:  max_misses_q  <= cfg.data;
					REG_ENTRY_COUNT: entry_count_q <= cfg.data[COUNT_W-1:0];
					default:         max_misses_q  <= max_misses_q;
				endcase
			end

			if (read_go) begin
				used_q    <= CW'(used_c);
				hit_vld_q <= 1'b0;
			end

			if (read_go || (state_q == ST_MATCH && state_d == ST_UPDATE)) begin
				rd_q <= '0;
			end else if (issue) begin
				rd_q <= rd_q + CW'(1);
			end

			if (issue) begin
				vld_s1 <= 1'b1;
			end else if (!stall) begin
				vld_s1 <= 1'b0;
			end

			if (state_q == ST_MATCH && match_hit) begin
				hit_vld_q <= 1'b1;
			end

			if (load_acc) begin
				pres_q[load_addr] <= 1'b0;
				cval_q[load_addr] <= 1'b1;
			end

			if (step) begin
				cval_q[idx_s1] <= 1'b1;
				if (ev_present) begin
					pres_q[idx_s1] <= 1'b1;
				end else if (ev_absent) begin
					pres_q[idx_s1] <= 1'b0;
				end
				if (ev) begin
					pend_vld_q <= 1'b1;
				end
			end else if (state_q == ST_FLUSH && out_free) begin
				pend_vld_q <= 1'b0;
			end

			if (out_from_step || (state_q == ST_FLUSH && pend_vld_q && out_free)) begin
				out_vld_q <= 1'b1;
			end else if (evt.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (read_go) begin
			tid_q   <= req.tid_value[TW-1:0];
			mask_q  <= mask_c;
			limit_q <= (max_misses_q == '0) ? MISS_W'(1) : max_misses_q;
		end
		if (issue) begin
			idx_s1 <= rd_q[IW-1:0];
		end
		if (state_q == ST_MATCH && match_hit) begin
			hit_q <= idx_s1;
		end
		if (step && ev) begin
			pend_q.entry   <= INDEX_W'(idx_s1);
			pend_q.present <= ev_present;
		end
		if (out_from_step) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end else if (state_q == ST_FLUSH && pend_vld_q && out_free) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!pend_vld_q && !vld_s1))
		else $error("pending event or read in flight while idle");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (rd_q <= used_q))
		else $error("walk counter past the entries in use");

	a_flush_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && flush_go) |=> (state_q == ST_IDLE))
		else $error("flush did not return to idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !evt.ready) |=> $stable(out_q) && $stable(out_last_q))
		else $error("stalled event register overwritten");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && hit_vld_q) |-> (CW'(hit_q) < used_q))
		else $error("matched entry outside the entries in use");

endmodule
